// ----- src/fmc_pkg.sv -----
// fmc_pkg: shared types, register map, section and error codes, char map and crc step
// used by every module of the fsk message framer
// no dependencies
package fmc_pkg;

    // default payload length limit in characters
    localparam int MAX_LEN_DEF = 1024;

    // apb port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // crc-8 generator polynomial
    localparam logic [7:0] CRC_POLY = 8'h07;

    // register indexes
    localparam logic [2:0] REG_MODE       = 3'd0;
    localparam logic [2:0] REG_TWO_NOTES  = 3'd1;
    localparam logic [2:0] REG_FOUR_NOTES = 3'd2;
    localparam logic [2:0] REG_SYM_TICKS  = 3'd3;
    localparam logic [2:0] REG_REST_TICKS = 3'd4;
    localparam logic [2:0] REG_REST_NOTE  = 3'd5;
    localparam logic [2:0] REG_START_MARK = 3'd6;
    localparam logic [2:0] REG_END_MARK   = 3'd7;

    // section codes
    localparam logic [1:0] SECT_START   = 2'd0;
    localparam logic [1:0] SECT_PAYLOAD = 2'd1;
    localparam logic [1:0] SECT_CRC     = 2'd2;
    localparam logic [1:0] SECT_END     = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BADCHAR = 2'd1;
    localparam logic [1:0] ERR_TOOLONG = 2'd2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_ERR  = 4'b1000
    } fmc_state_t;

    // input word
    typedef struct packed {
        logic [7:0] character;
        logic       end_of_message;
    } fmc_in_t;

    // output word
    typedef struct packed {
        logic [7:0] note_out;
        logic [6:0] note_ticks;
        logic [7:0] pause_note;
        logic [6:0] pause_ticks;
        logic [1:0] symbol_value;
        logic [1:0] section;
        logic [1:0] error_code;
        logic       last_of_run;
    } fmc_out_t;

    // configuration registers
    typedef struct packed {
        logic        mode_four_tone;
        logic [15:0] two_tone_notes;
        logic [31:0] four_tone_notes;
        logic [6:0]  symbol_ticks;
        logic [6:0]  rest_ticks;
        logic [7:0]  rest_note;
        logic [5:0]  start_marker;
        logic [5:0]  end_marker;
    } fmc_cfg_t;

    // control from sequencer to the shift unit
    typedef struct packed {
        logic load;
        logic shift;
        logic crc_clear;
        logic crc_en;
        logic four_tone;
    } fmc_shift_ctrl_t;

    // status from the shift unit
    typedef struct packed {
        logic [1:0] symbol;
        logic       seg_last;
    } fmc_shift_stat_t;

    // char to 6-bit code, msb is the valid flag
    function automatic logic [6:0] map_char(input logic [7:0] c);
        logic [7:0] lc;
        logic [6:0] res;
        lc  = c;
        res = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            lc = c + 8'h20;
        end
        if (lc >= 8'h61 && lc <= 8'h7A)
        begin
            res = {1'b1, 6'(lc - 8'h61)};
        end
        else if (lc >= 8'h30 && lc <= 8'h39)
        begin
            res = {1'b1, 6'(lc - 8'h30 + 8'd26)};
        end
        else
        begin
            unique case (lc)
                8'h20:   res = {1'b1, 6'd36};
                8'h2C:   res = {1'b1, 6'd37};
                8'h3A:   res = {1'b1, 6'd38};
                8'h27:   res = {1'b1, 6'd39};
                8'h22:   res = {1'b1, 6'd40};
                8'h0A:   res = {1'b1, 6'd41};
                default: res = 7'd0;
            endcase
        end
        return res;
    endfunction

    // one msb-first crc step
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic din);
        logic [7:0] nxt;
        nxt = {crc[6:0], 1'b0};
        if (crc[7] ^ din)
        begin
            nxt = nxt ^ CRC_POLY;
        end
        return nxt;
    endfunction

endpackage

// ----- src/fsk_message_framer_crc8_unit.sv -----
// fsk_message_framer_crc8_unit: top level of the fsk message framer with crc-8
// depends on fmc_pkg, fmc_regs, fmc_shift_unit
//
// Takes one message character per input word and sends tone symbols, one output word per
// symbol: start marker before the first character, the character code, and after the last
// character the crc-8 and the end marker. Bad characters or overlong messages give one
// error word, then input is dropped up to the end of the message. After a character is
// taken, a small sequencer drives one shared shift unit: each code segment is loaded in the
// load state and then sent one symbol per output word, 6 in 2FSK or 3 in 4FSK for a code and
// 8 or 4 for the crc, while the input stalls. The output register lets the next character
// be taken while the last word still waits.
module fsk_message_framer_crc8_unit #(
    parameter int MAX_LEN = fmc_pkg::MAX_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fmc_pkg::ADDR_W-1:0]  paddr,
    input  logic [fmc_pkg::DATA_W-1:0]  pwdata,
    output logic [fmc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        char_valid,
    output logic                        char_stall,
    input  fmc_pkg::fmc_in_t            char_word,
    output logic                        sym_valid,
    input  logic                        sym_stall,
    output fmc_pkg::fmc_out_t           sym_word
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    fmc_pkg::fmc_cfg_t        cfg;
    fmc_pkg::fmc_shift_ctrl_t sh_ctrl;
    fmc_pkg::fmc_shift_stat_t sh_stat;
    logic [7:0]               crc;

    fmc_pkg::fmc_state_t state_reg, state_next;
    logic                in_msg_reg, in_msg_next;
    logic                abort_reg, abort_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [1:0]          sect_reg, sect_next;
    logic [1:0]          err_reg, err_next;
    logic [5:0]          code_reg, code_next;
    logic                eom_reg, eom_next;
    logic                sym_valid_reg, sym_valid_next;
    fmc_pkg::fmc_out_t   sym_word_reg, sym_word_next;

    logic       accept;
    logic       out_free;
    logic [6:0] mapped;
    logic       final_seg;
    logic [7:0] load_value;
    logic [3:0] load_bits;
    logic [7:0] note;

    fmc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fmc_shift_unit u_shift (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (sh_ctrl),
        .load_value (load_value),
        .load_bits  (load_bits),
        .stat       (sh_stat),
        .crc        (crc)
    );

    assign char_stall = (state_reg != fmc_pkg::ST_IDLE);
    assign accept     = char_valid && !char_stall;
    assign out_free   = !sym_valid_reg || !sym_stall;
    assign mapped     = fmc_pkg::map_char(char_word.character);
    assign sym_valid  = sym_valid_reg;
    assign sym_word   = sym_word_reg;
    assign final_seg  = (sect_reg == fmc_pkg::SECT_END)
                     || (sect_reg == fmc_pkg::SECT_PAYLOAD && !eom_reg);

    // segment source select
    always_comb
    begin
        load_bits = 4'd6;
        unique case (sect_reg)
            fmc_pkg::SECT_START:   load_value = {cfg.start_marker, 2'b00};
            fmc_pkg::SECT_PAYLOAD: load_value = {code_reg, 2'b00};
            fmc_pkg::SECT_CRC:
            begin
                load_value = crc;
                load_bits  = 4'd8;
            end
            fmc_pkg::SECT_END:     load_value = {cfg.end_marker, 2'b00};
            default:               load_value = 8'd0;
        endcase
    end

    // tone note lookup
    always_comb
    begin
        if (cfg.mode_four_tone)
        begin
            unique case (sh_stat.symbol)
                2'd0:    note = cfg.four_tone_notes[7:0];
                2'd1:    note = cfg.four_tone_notes[15:8];
                2'd2:    note = cfg.four_tone_notes[23:16];
                2'd3:    note = cfg.four_tone_notes[31:24];
                default: note = 8'd0;
            endcase
        end
        else
        begin
            note = sh_stat.symbol[0] ? cfg.two_tone_notes[15:8] : cfg.two_tone_notes[7:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        in_msg_next    = in_msg_reg;
        abort_next     = abort_reg;
        count_next     = count_reg;
        sect_next      = sect_reg;
        err_next       = err_reg;
        code_next      = code_reg;
        eom_next       = eom_reg;
        sym_valid_next = out_free ? 1'b0 : sym_valid_reg;
        sym_word_next  = sym_word_reg;

        sh_ctrl           = '0;
        sh_ctrl.four_tone = cfg.mode_four_tone;

        unique case (state_reg)
            fmc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    eom_next = char_word.end_of_message;
                    if (abort_reg)
                    begin
                        // drop until end of message
                        if (char_word.end_of_message)
                        begin
                            in_msg_next = 1'b0;
                            abort_next  = 1'b0;
                            count_next  = '0;
                        end
                    end
                    else if (count_reg >= CNT_W'(MAX_LEN))
                    begin
                        err_next   = fmc_pkg::ERR_TOOLONG;
                        state_next = fmc_pkg::ST_ERR;
                    end
                    else if (!mapped[6])
                    begin
                        err_next   = fmc_pkg::ERR_BADCHAR;
                        state_next = fmc_pkg::ST_ERR;
                    end
                    else
                    begin
                        code_next   = mapped[5:0];
                        count_next  = count_reg + 1'b1;
                        in_msg_next = 1'b1;
                        if (!in_msg_reg)
                        begin
                            sect_next         = fmc_pkg::SECT_START;
                            sh_ctrl.crc_clear = 1'b1;
                        end
                        else
                        begin
                            sect_next = fmc_pkg::SECT_PAYLOAD;
                        end
                        state_next = fmc_pkg::ST_LOAD;
                    end
                end
            end

            fmc_pkg::ST_ERR:
            begin
                if (out_free)
                begin
                    sym_valid_next             = 1'b1;
                    sym_word_next              = '0;
                    sym_word_next.error_code   = err_reg;
                    sym_word_next.last_of_run  = 1'b1;
                    if (eom_reg)
                    begin
                        in_msg_next = 1'b0;
                        abort_next  = 1'b0;
                        count_next  = '0;
                    end
                    else
                    begin
                        in_msg_next = 1'b1;
                        abort_next  = 1'b1;
                    end
                    state_next = fmc_pkg::ST_IDLE;
                end
            end

            fmc_pkg::ST_LOAD:
            begin
                sh_ctrl.load = 1'b1;
                state_next   = fmc_pkg::ST_EMIT;
            end

            fmc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    sh_ctrl.shift  = 1'b1;
                    sh_ctrl.crc_en = (sect_reg == fmc_pkg::SECT_PAYLOAD);
                    sym_valid_next = 1'b1;
                    sym_word_next.note_out     = note;
                    sym_word_next.note_ticks   = cfg.symbol_ticks;
                    sym_word_next.pause_note   = cfg.rest_note;
                    sym_word_next.pause_ticks  = cfg.rest_ticks;
                    sym_word_next.symbol_value = sh_stat.symbol;
                    sym_word_next.section      = sect_reg;
                    sym_word_next.error_code   = fmc_pkg::ERR_NONE;
                    sym_word_next.last_of_run  = sh_stat.seg_last && final_seg;
                    if (sh_stat.seg_last)
                    begin
                        if (final_seg)
                        begin
                            state_next = fmc_pkg::ST_IDLE;
                            if (sect_reg == fmc_pkg::SECT_END)
                            begin
                                in_msg_next = 1'b0;
                                count_next  = '0;
                            end
                        end
                        else
                        begin
                            sect_next  = sect_reg + 2'd1;
                            state_next = fmc_pkg::ST_LOAD;
                        end
                    end
                end
            end

            default:
            begin
                state_next = fmc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmc_pkg::ST_IDLE;
            in_msg_reg    <= 1'b0;
            abort_reg     <= 1'b0;
            count_reg     <= '0;
            sym_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            abort_reg     <= abort_next;
            count_reg     <= count_next;
            sym_valid_reg <= sym_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sect_reg     <= sect_next;
        err_reg      <= err_next;
        code_reg     <= code_next;
        eom_reg      <= eom_next;
        sym_word_reg <= sym_word_next;
    end

endmodule

// ----- src/fmc_regs.sv -----
// fmc_regs: apb configuration register file of the fsk message framer
// depends on fmc_pkg
module fmc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fmc_pkg::ADDR_W-1:0]  paddr,
    input  logic [fmc_pkg::DATA_W-1:0]  pwdata,
    output logic [fmc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output fmc_pkg::fmc_cfg_t           cfg
);

    fmc_pkg::fmc_cfg_t cfg_reg;
    fmc_pkg::fmc_cfg_t cfg_next;
    logic [2:0]        idx;
    logic              wr_en;

    assign idx    = paddr[fmc_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                fmc_pkg::REG_MODE:       cfg_next.mode_four_tone  = pwdata[0];
                fmc_pkg::REG_TWO_NOTES:  cfg_next.two_tone_notes  = pwdata[15:0];
                fmc_pkg::REG_FOUR_NOTES: cfg_next.four_tone_notes = pwdata[31:0];
                fmc_pkg::REG_SYM_TICKS:  cfg_next.symbol_ticks    = pwdata[6:0];
                fmc_pkg::REG_REST_TICKS: cfg_next.rest_ticks      = pwdata[6:0];
                fmc_pkg::REG_REST_NOTE:  cfg_next.rest_note       = pwdata[7:0];
                fmc_pkg::REG_START_MARK: cfg_next.start_marker    = pwdata[5:0];
                fmc_pkg::REG_END_MARK:   cfg_next.end_marker      = pwdata[5:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg              <= '0;
            cfg_reg.symbol_ticks <= 7'd1;
            cfg_reg.rest_ticks   <= 7'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            fmc_pkg::REG_MODE:       prdata = {31'd0, cfg_reg.mode_four_tone};
            fmc_pkg::REG_TWO_NOTES:  prdata = {16'd0, cfg_reg.two_tone_notes};
            fmc_pkg::REG_FOUR_NOTES: prdata = cfg_reg.four_tone_notes;
            fmc_pkg::REG_SYM_TICKS:  prdata = {25'd0, cfg_reg.symbol_ticks};
            fmc_pkg::REG_REST_TICKS: prdata = {25'd0, cfg_reg.rest_ticks};
            fmc_pkg::REG_REST_NOTE:  prdata = {24'd0, cfg_reg.rest_note};
            fmc_pkg::REG_START_MARK: prdata = {26'd0, cfg_reg.start_marker};
            fmc_pkg::REG_END_MARK:   prdata = {26'd0, cfg_reg.end_marker};
            default:                 prdata = '0;
        endcase
    end

endmodule

// ----- src/fmc_shift_unit.sv -----
// fmc_shift_unit: shared segment shifter that slices codes into symbols and runs the crc
// depends on fmc_pkg
module fmc_shift_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fmc_pkg::fmc_shift_ctrl_t ctrl,
    input  logic [7:0]               load_value,
    input  logic [3:0]               load_bits,
    output fmc_pkg::fmc_shift_stat_t stat,
    output logic [7:0]               crc
);

    logic [7:0] seg_reg;
    logic [7:0] seg_next;
    logic [3:0] bits_reg;
    logic [3:0] bits_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [7:0] crc_one;
    logic [3:0] step;

    assign step          = ctrl.four_tone ? 4'd2 : 4'd1;
    assign stat.symbol   = ctrl.four_tone ? seg_reg[7:6] : {1'b0, seg_reg[7]};
    assign stat.seg_last = (bits_reg == step);
    assign crc           = crc_reg;

    // segment load and shift
    always_comb
    begin
        seg_next  = seg_reg;
        bits_next = bits_reg;
        if (ctrl.load)
        begin
            seg_next  = load_value;
            bits_next = load_bits;
        end
        else if (ctrl.shift)
        begin
            seg_next  = ctrl.four_tone ? {seg_reg[5:0], 2'b00} : {seg_reg[6:0], 1'b0};
            bits_next = bits_reg - step;
        end
    end

    // crc over the bits shifted out
    always_comb
    begin
        crc_one  = fmc_pkg::crc_step(crc_reg, seg_reg[7]);
        crc_next = crc_reg;
        if (ctrl.crc_clear)
        begin
            crc_next = 8'd0;
        end
        else if (ctrl.crc_en)
        begin
            crc_next = ctrl.four_tone ? fmc_pkg::crc_step(crc_one, seg_reg[6]) : crc_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= 4'd0;
            crc_reg  <= 8'd0;
        end
        else
        begin
            bits_reg <= bits_next;
            crc_reg  <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

endmodule

// ----- src/fmc_checker.sv -----
// fmc_checker: port-level assertions for the fsk message framer, bound to the top level
// depends on fmc_pkg and fsk_message_framer_crc8_unit
module fmc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        char_valid,
    input  logic                        char_stall,
    input  logic                        sym_valid,
    input  logic                        sym_stall,
    input  fmc_pkg::fmc_out_t           sym_word
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_stall |=> sym_valid && $stable(sym_word))
        else $error("output word changed while stalled");

    // error words are bare and close the run
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid && sym_word.error_code != fmc_pkg::ERR_NONE |->
            sym_word.last_of_run && sym_word.note_out == 8'd0 &&
            sym_word.section == fmc_pkg::SECT_START && sym_word.note_ticks == 7'd0)
        else $error("malformed error word");

    // no undefined error code
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        sym_valid |-> sym_word.error_code != 2'd3)
        else $error("undefined error code");

    // input stall rises only after a word was taken
    a_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(char_stall) |-> $past(char_valid && !char_stall))
        else $error("input stall without an accepted word");

endmodule

bind fsk_message_framer_crc8_unit fmc_checker u_fmc_checker (.*);
